// ===== src/cor_pkg.sv =====
// ============================================================================
// cor_pkg
// Shared types and constants for the circle outline rasterizer: command and
// pass records, state machine encodings and register indexes.
// ============================================================================
`default_nettype none

package cor_pkg;

    // largest radius drawn; larger requests saturate to it
    localparam logic [3:0] MAX_RADIUS  = 4'd11;
    // frame sizes above this act as this
    localparam logic [6:0] FRAME_LIMIT = 7'd64;
    // most pixel writes one circle may produce
    localparam logic [6:0] RESULT_CAP  = 7'd64;
    // pass queue between the generator and the emitter (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // latched circle command, held for the whole circle
    typedef struct packed {
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [23:0] color;
        logic [6:0]  width;
        logic [6:0]  height;
    } cmd_t;

    // one loop pass: offsets and a flag for the final pass
    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic       last;
    } pass_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_RUN,
        FR_WAIT
    } front_state_t;

    typedef enum logic [0:0] {
        BK_WORK,
        BK_FLUSH
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/cor_pass_fifo.sv =====
// ============================================================================
// cor_pass_fifo
// Short queue of loop passes between the pass generator and the pixel
// emitter, so that each side stalls on its own.
// ============================================================================
`default_nettype none

module cor_pass_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire cor_pkg::pass_t push_data,
    input  wire logic          pop,
    output cor_pkg::pass_t     head,
    output logic               empty,
    output logic               full
);

    cor_pkg::pass_t entry_mem [cor_pkg::QUEUE_DEPTH];
    logic [cor_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [cor_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [cor_pkg::QCNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == cor_pkg::QCNT_W'(cor_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/cor_front.sv =====
// ============================================================================
// cor_front
// Accepts a circle request, latches it and runs the Bresenham decision
// loop, pushing one pass record per cycle into the pass queue while it is not full.
// ============================================================================
`default_nettype none

module cor_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [7:0]     center_x,
    input  wire logic [7:0]     center_y,
    input  wire logic [3:0]     circle_radius,
    input  wire logic [23:0]    draw_color,
    input  wire logic [6:0]     frame_width,
    input  wire logic [6:0]     frame_height,
    input  wire logic           queue_full,
    input  wire logic           back_done,
    output logic                busy,
    output logic                push,
    output cor_pkg::pass_t      push_data,
    output cor_pkg::cmd_t       cmd
);

    cor_pkg::front_state_t state_reg, state_next;

    logic signed [4:0] x_reg, x_next;
    logic signed [4:0] y_reg, y_next;
    logic signed [6:0] d_reg, d_next;
    cor_pkg::cmd_t     cmd_reg, cmd_next;

    logic              accept;
    logic [3:0]        radius_sat;
    logic signed [4:0] y_inc;
    logic signed [4:0] x_dec;
    logic signed [7:0] d_wide;
    logic signed [7:0] y_quad;
    logic signed [7:0] x_quad;
    logic signed [7:0] d_step;
    logic signed [4:0] x_step;
    logic              final_pass;

    assign busy   = (state_reg != cor_pkg::FR_IDLE);
    assign accept = start && (state_reg == cor_pkg::FR_IDLE);
    assign cmd    = cmd_reg;

    // radius saturation
    assign radius_sat = (circle_radius > cor_pkg::MAX_RADIUS) ? cor_pkg::MAX_RADIUS
                                                               : circle_radius;

    // decision update: y steps first, x steps after the update
    assign y_inc  = y_reg + 5'sd1;
    assign x_dec  = x_reg - 5'sd1;
    assign d_wide = {d_reg[6], d_reg};
    assign y_quad = {y_inc[4], y_inc, 2'b00};
    assign x_quad = {x_reg[4], x_reg, 2'b00};

    always_comb
    begin
        if (d_reg <= 7'sd0)
        begin
            d_step = d_wide + y_quad + 8'sd6;
            x_step = x_reg;
        end
        else
        begin
            d_step = d_wide + (y_quad - x_quad) + 8'sd10;
            x_step = x_dec;
        end
    end

    assign final_pass = (x_step < y_inc);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cor_pkg::FR_IDLE:
            begin
                if (start)
                begin
                    state_next = cor_pkg::FR_RUN;
                end
            end
            cor_pkg::FR_RUN:
            begin
                if (!queue_full && final_pass)
                begin
                    state_next = cor_pkg::FR_WAIT;
                end
            end
            cor_pkg::FR_WAIT:
            begin
                if (back_done)
                begin
                    state_next = cor_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = cor_pkg::FR_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        push      = 1'b0;
        push_data = '{x: x_reg[3:0], y: y_reg[3:0], last: final_pass};
        x_next    = x_reg;
        y_next    = y_reg;
        d_next    = d_reg;
        cmd_next  = cmd_reg;
        case (state_reg)
            cor_pkg::FR_IDLE:
            begin
                if (accept)
                begin
                    x_next         = {1'b0, radius_sat};
                    y_next         = 5'sd0;
                    d_next         = 7'sd3 - $signed({2'b00, radius_sat, 1'b0});
                    cmd_next.cx    = center_x;
                    cmd_next.cy    = center_y;
                    cmd_next.color = draw_color;
                    cmd_next.width = (frame_width > cor_pkg::FRAME_LIMIT)
                                     ? cor_pkg::FRAME_LIMIT : frame_width;
                    cmd_next.height = (frame_height > cor_pkg::FRAME_LIMIT)
                                      ? cor_pkg::FRAME_LIMIT : frame_height;
                end
            end
            cor_pkg::FR_RUN:
            begin
                if (!queue_full)
                begin
                    push   = 1'b1;
                    x_next = x_step;
                    y_next = y_inc;
                    d_next = d_step[6:0];
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // state and loop registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cor_pkg::FR_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            d_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            d_reg     <= d_next;
        end
    end

    // latched request
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

// ===== src/cor_back.sv =====
// ============================================================================
// cor_back
// Walks the eight symmetric points of each queued pass, clips them to the
// frame and emits pixel writes, holding one pixel back to flag the last.
// ============================================================================
`default_nettype none

module cor_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cor_pkg::cmd_t  cmd,
    input  wire cor_pkg::pass_t head,
    input  wire logic           queue_empty,
    output logic                pop,
    output logic                done,
    output logic                pixel_valid,
    output logic [5:0]          pixel_x,
    output logic [5:0]          pixel_y,
    output logic [23:0]         pixel_color,
    output logic                last_pixel
);

    cor_pkg::back_state_t state_reg, state_next;

    logic [2:0] octant_reg, octant_next;
    logic [6:0] count_reg, count_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [5:0] pend_x_reg, pend_x_next;
    logic [5:0] pend_y_reg, pend_y_next;
    logic       out_valid_reg, out_valid_next;
    logic [5:0] out_x_reg, out_x_next;
    logic [5:0] out_y_reg, out_y_next;
    logic [23:0] out_color_reg, out_color_next;
    logic       out_last_reg, out_last_next;

    logic [3:0] off_col;
    logic [3:0] off_row;
    logic [9:0] point_x;
    logic [9:0] point_y;
    logic       visible;

    // point of the current octant, relative to the center
    always_comb
    begin
        off_col = octant_reg[2] ? head.y : head.x;
        off_row = octant_reg[2] ? head.x : head.y;
        point_x = octant_reg[0] ? ({2'b00, cmd.cx} - {6'b0, off_col})
                                : ({2'b00, cmd.cx} + {6'b0, off_col});
        point_y = octant_reg[1] ? ({2'b00, cmd.cy} - {6'b0, off_row})
                                : ({2'b00, cmd.cy} + {6'b0, off_row});
    end

    // frame clip and result cap
    assign visible = !point_x[9] && (point_x[8:0] < {2'b00, cmd.width}) &&
                     !point_y[9] && (point_y[8:0] < {2'b00, cmd.height}) &&
                     (count_reg < cor_pkg::RESULT_CAP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cor_pkg::BK_WORK:
            begin
                if (!queue_empty && (octant_reg == 3'd7) && head.last)
                begin
                    state_next = cor_pkg::BK_FLUSH;
                end
            end
            cor_pkg::BK_FLUSH:
            begin
                state_next = cor_pkg::BK_WORK;
            end
            default:
            begin
                state_next = cor_pkg::BK_WORK;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop             = 1'b0;
        done            = 1'b0;
        octant_next     = octant_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_valid_next  = 1'b0;
        out_x_next      = pend_x_reg;
        out_y_next      = pend_y_reg;
        out_color_next  = cmd.color;
        out_last_next   = 1'b0;
        case (state_reg)
            cor_pkg::BK_WORK:
            begin
                if (!queue_empty)
                begin
                    octant_next = octant_reg + 3'd1;
                    pop         = (octant_reg == 3'd7);
                    if (visible)
                    begin
                        // release the held pixel, hold the new one
                        out_valid_next  = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_x_next     = point_x[5:0];
                        pend_y_next     = point_y[5:0];
                        count_next      = count_reg + 7'd1;
                    end
                end
            end
            cor_pkg::BK_FLUSH:
            begin
                // held pixel is the final one of the circle
                out_valid_next  = pend_valid_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
                count_next      = '0;
                done            = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cor_pkg::BK_WORK;
            octant_reg     <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            octant_reg     <= octant_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel  = out_last_reg;

endmodule

`default_nettype wire

// ===== src/circle_outline_rasterizer_unit.sv =====
// ============================================================================
// circle_outline_rasterizer_unit
// Bresenham circle outline rasterizer: one circle request in, clipped pixel
// writes out, with frame size registers.
// ============================================================================
// first pixel write: the emitter holds each visible point until the next one
//   or the flush releases it; a new request is taken only after the flush
//   (one octant point per cycle while passes are queued, at most 8 passes)
// busy stays high until the held final pixel is released
// reset: frame width and height return to 32, all control state clears
// pixel writes cannot be stalled by the receiver
`default_nettype none

module circle_outline_rasterizer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  center_x,
    input  wire logic [7:0]  center_y,
    input  wire logic [3:0]  circle_radius,
    input  wire logic [23:0] draw_color,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    output logic             pixel_valid,
    output logic [5:0]       pixel_x,
    output logic [5:0]       pixel_y,
    output logic [23:0]      pixel_color,
    output logic             last_pixel
);

    logic [6:0] frame_width_reg;
    logic [6:0] frame_height_reg;

    cor_pkg::pass_t push_data;
    cor_pkg::pass_t head;
    cor_pkg::cmd_t  cmd;
    logic           push;
    logic           pop;
    logic           queue_empty;
    logic           queue_full;
    logic           back_done;

    // frame size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 7'd32;
            frame_height_reg <= 7'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cor_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                cor_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // pass generator
    cor_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .center_x     (center_x),
        .center_y     (center_y),
        .circle_radius(circle_radius),
        .draw_color   (draw_color),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .queue_full   (queue_full),
        .back_done    (back_done),
        .busy         (busy),
        .push         (push),
        .push_data    (push_data),
        .cmd          (cmd)
    );

    // pass queue
    cor_pass_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // pixel emitter
    cor_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .queue_empty(queue_empty),
        .pop        (pop),
        .done       (back_done),
        .pixel_valid(pixel_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_color(pixel_color),
        .last_pixel (last_pixel)
    );

endmodule

`default_nettype wire
